>>> rtl/lfr_pkg.sv
// Package for the line framed receive ring: sizes, register map and payload types.
// Used by lfr_byte_ring and line_framed_rx_ring; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

   localparam int RING_BYTES = 64;
   localparam int NUM_SLOTS  = 4;

   localparam int PTR_W  = $clog2(RING_BYTES);
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LEN_W  = $clog2(RING_BYTES + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int                  REG_TERMINATOR_MAX  = 0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TERMINATOR_MAX =
      CSR_ADDR_W'(4 * REG_TERMINATOR_MAX);
   localparam logic [7:0]          TERMINATOR_RESET    = 8'd13;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       empty_res;
      logic [6:0] message_length;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ring_req_type;

endpackage

`default_nettype wire

>>> rtl/lfr_byte_ring.sv
// Byte ring storage: one write port and one registered read port.
// Depends on lfr_pkg for the ring size and the access struct.
`timescale 1ns / 1ps
`default_nettype none

module lfr_byte_ring (
   input  wire logic                  clock,
   input  wire lfr_pkg::ring_req_type ring_req,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem [lfr_pkg::RING_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         mem[ring_req.wr_addr] <= ring_req.wr_data;
      end
      if (ring_req.rd_en) begin
         rd_data_ff <= mem[ring_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/line_framed_rx_ring.sv
// Top level of the line framed receive ring: framer, descriptor ring and readout sequencer.
// Depends on lfr_pkg and instantiates lfr_byte_ring.
`timescale 1ns / 1ps
`default_nettype none

// The block gathers received UART bytes into messages that end on any byte whose
// unsigned value is at or below the terminator_max register (reset value 13).
// On a receive request (op 0) the byte goes into a 64 entry byte
// ring, and a terminator on a non-empty message stores a zero byte and files the
// message in the next of four descriptor slots. A terminator on an empty message
// is ignored, and a message stops growing at 63 data bytes, so that its length
// with the zero byte never passes the ring size. A read request (op 1) returns
// the oldest filed message one byte per response, zero byte included, with last
// set on the final byte; if nothing is filed it returns one response with
// empty_res and last set. The block takes no new request until the whole
// response is delivered. Each message byte goes through a memory fetch state,
// a load state into the output register and a send state that waits on the
// response channel; an empty read goes straight to the send state. The ring
// and descriptors do not guard against overrun: old bytes are overwritten, and
// filing a message clears the next slot, discarding any unread message in it.
// terminator_max sits at address 0 of the register port and should be written
// only while the block is idle.

module line_framed_rx_ring (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire lfr_pkg::req_type                  req_data,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output lfr_pkg::rsp_type                       rsp_data,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lfr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [lfr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lfr_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   localparam int PTR_W  = lfr_pkg::PTR_W;
   localparam int SLOT_W = lfr_pkg::SLOT_W;
   localparam int LEN_W  = lfr_pkg::LEN_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(lfr_pkg::RING_BYTES - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(lfr_pkg::NUM_SLOTS - 1);
   localparam logic [LEN_W-1:0]  LEN_MAX_DATA = LEN_W'(lfr_pkg::RING_BYTES - 1);

   // Configuration register.
   logic [7:0] term_max_ff;
   logic       csr_write;

   // Framer state.
   logic [PTR_W-1:0]  write_pos_ff, write_pos_in;
   logic [PTR_W-1:0]  msg_start_ff, msg_start_in;
   logic [LEN_W-1:0]  fill_len_ff, fill_len_in;
   logic [SLOT_W-1:0] fill_slot_ff, fill_slot_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic [SLOT_W-1:0] fill_slot_next;
   logic [SLOT_W-1:0] read_slot_next;
   logic [lfr_pkg::NUM_SLOTS-1:0] slot_ready_ff, slot_ready_in;

   // Descriptor payload: written at the fill slot, read at the read slot.
   logic [PTR_W-1:0] slot_start_ff [lfr_pkg::NUM_SLOTS];
   logic [LEN_W-1:0] slot_len_ff   [lfr_pkg::NUM_SLOTS];
   logic             desc_write;

   // Readout sequencer.
   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] msg_len_ff, msg_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lfr_pkg::rsp_type rsp_ff, rsp_in;

   // The one pointer incrementer, shared between the write pointer in idle
   // and the readout address while a message streams out.
   logic [PTR_W-1:0] inc_src;
   logic [PTR_W-1:0] inc_out;

   lfr_pkg::ring_req_type ring_req;
   logic [7:0]            ring_rd_data;

   logic req_fire;
   logic rsp_fire;
   logic is_term;

   lfr_byte_ring u_ring (
      .clock    (clock),
      .ring_req (ring_req),
      .rd_data  (ring_rd_data)
   );

   // Register port: pready is tied high, so a write lands on its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == lfr_pkg::ADDR_TERMINATOR_MAX);

   always_comb begin
      if (csr_paddr == lfr_pkg::ADDR_TERMINATOR_MAX) begin
         csr_prdata = {{(lfr_pkg::CSR_DATA_W - 8){1'b0}}, term_max_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_max_ff <= lfr_pkg::TERMINATOR_RESET;
      end else if (csr_write) begin
         term_max_ff <= csr_pwdata[7:0];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign is_term   = (req_data.symbol <= term_max_ff);

   assign inc_src = (state_ff == ST_IDLE) ? write_pos_ff : rd_addr_ff;
   assign inc_out = (inc_src == PTR_LAST) ? '0 : inc_src + PTR_W'(1);

   assign fill_slot_next = (fill_slot_ff == SLOT_LAST) ? '0 : fill_slot_ff + SLOT_W'(1);
   assign read_slot_next = (read_slot_ff == SLOT_LAST) ? '0 : read_slot_ff + SLOT_W'(1);

   always_comb begin
      write_pos_in  = write_pos_ff;
      msg_start_in  = msg_start_ff;
      fill_len_in   = fill_len_ff;
      fill_slot_in  = fill_slot_ff;
      read_slot_in  = read_slot_ff;
      slot_ready_in = slot_ready_ff;
      desc_write    = 1'b0;
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      msg_len_in    = msg_len_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      ring_req.wr_en   = 1'b0;
      ring_req.wr_addr = write_pos_ff;
      ring_req.wr_data = req_data.symbol;
      ring_req.rd_en   = 1'b0;
      ring_req.rd_addr = rd_addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.op == lfr_pkg::OP_RECEIVE)) begin
               if (is_term) begin
                  // A terminator closes the message only if it holds bytes.
                  if (fill_len_ff != '0) begin
                     ring_req.wr_en   = 1'b1;
                     ring_req.wr_data = 8'd0;
                     write_pos_in     = inc_out;
                     msg_start_in     = inc_out;
                     desc_write       = 1'b1;
                     slot_ready_in[fill_slot_ff]   = 1'b1;
                     slot_ready_in[fill_slot_next] = 1'b0;
                     fill_slot_in     = fill_slot_next;
                     fill_len_in      = '0;
                  end
               end else if (fill_len_ff < LEN_MAX_DATA) begin
                  ring_req.wr_en = 1'b1;
                  write_pos_in   = inc_out;
                  fill_len_in    = fill_len_ff + LEN_W'(1);
               end
            end else if (req_fire) begin
               if (slot_ready_ff[read_slot_ff]) begin
                  rd_addr_in    = slot_start_ff[read_slot_ff];
                  remain_in     = slot_len_ff[read_slot_ff];
                  msg_len_in    = slot_len_ff[read_slot_ff];
                  slot_ready_in[read_slot_ff] = 1'b0;
                  read_slot_in  = read_slot_next;
                  state_in      = ST_FETCH;
               end else begin
                  rsp_in.data_byte      = 8'd0;
                  rsp_in.last           = 1'b1;
                  rsp_in.empty_res      = 1'b1;
                  rsp_in.message_length = 7'd0;
                  rsp_valid_in          = 1'b1;
                  remain_in             = LEN_W'(1);
                  state_in              = ST_SEND;
               end
            end
         end
         ST_FETCH: begin
            ring_req.rd_en = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_in.data_byte      = ring_rd_data;
            rsp_in.last           = (remain_ff == LEN_W'(1));
            rsp_in.empty_res      = 1'b0;
            rsp_in.message_length = 7'(msg_len_ff);
            rsp_valid_in          = 1'b1;
            rd_addr_in            = inc_out;
            remain_in             = remain_ff - LEN_W'(1);
            state_in              = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff  <= '0;
         msg_start_ff  <= '0;
         fill_len_ff   <= '0;
         fill_slot_ff  <= '0;
         read_slot_ff  <= '0;
         slot_ready_ff <= '0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         remain_ff     <= '0;
      end else begin
         write_pos_ff  <= write_pos_in;
         msg_start_ff  <= msg_start_in;
         fill_len_ff   <= fill_len_in;
         fill_slot_ff  <= fill_slot_in;
         read_slot_ff  <= read_slot_in;
         slot_ready_ff <= slot_ready_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         remain_ff     <= remain_in;
      end
   end

   // Payload registers carry no reset; they are only read once loaded.
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      msg_len_ff <= msg_len_in;
      rsp_ff     <= rsp_in;
      if (desc_write) begin
         slot_start_ff[fill_slot_ff] <= msg_start_ff;
         slot_len_ff[fill_slot_ff]   <= fill_len_ff + LEN_W'(1);
      end
   end

endmodule

`default_nettype wire

>>> test/line_framed_rx_ring_test.sv
// Self-checking testbench for line_framed_rx_ring: random and directed receive/read traffic.
// Depends on lfr_pkg and the line_framed_rx_ring RTL; the expected readout comes from
// a framer copy kept inside this file.
`timescale 1ns / 1ps

module line_framed_rx_ring_test;

   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      lfr_pkg::req_type request;
      logic             wait_drain;
   } stim_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_ready;
   lfr_pkg::req_type               req_data    = '0;
   logic                           rsp_valid;
   logic                           rsp_ready   = 1'b0;
   lfr_pkg::rsp_type               rsp_data;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [lfr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [lfr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [lfr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Framer copy: byte ring, descriptor slots and the terminator setting.
   logic [7:0] ring_copy [lfr_pkg::RING_BYTES];
   int         ring_wr    = 0;
   int         msg_begin  = 0;
   logic       slot_full  [lfr_pkg::NUM_SLOTS];
   int         slot_count [lfr_pkg::NUM_SLOTS];
   int         slot_base  [lfr_pkg::NUM_SLOTS];
   int         fill_idx   = 0;
   int         read_idx   = 0;
   logic [7:0] term_limit = lfr_pkg::TERMINATOR_RESET;

   lfr_pkg::rsp_type readout_queue [$];
   stim_type         pending [$];
   stim_type         next_entry;

   int  req_issued    = 0;
   int  req_accepted  = 0;
   int  send_gap      = 0;
   int  rsp_stall     = 0;
   int  hold_requests = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   int  error_count   = 0;
   int  cycle_count   = 0;
   bit  sender_gaps   = 1'b1;
   bit  receiver_gaps = 1'b1;

   line_framed_rx_ring uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
   endfunction

   function automatic void store_byte(input logic [7:0] value);
      ring_copy[ring_wr] = value;
      ring_wr = (ring_wr + 1) % lfr_pkg::RING_BYTES;
   endfunction

   // Applies one accepted request to the framer copy and queues the bytes it reads out.
   function automatic void frame_request(input lfr_pkg::req_type item);
      int               s;
      int               n;
      int               a;
      lfr_pkg::rsp_type word;
      if (item.op == lfr_pkg::OP_RECEIVE) begin
         s = fill_idx;
         if (item.symbol <= term_limit) begin
            // A terminator only closes a message that holds at least one byte.
            if (slot_count[s] > 0) begin
               store_byte(8'h00);
               slot_count[s]++;
               slot_base[s] = msg_begin;
               msg_begin = ring_wr;
               slot_full[s] = 1'b1;
               fill_idx = (s + 1) % lfr_pkg::NUM_SLOTS;
               slot_count[fill_idx] = 0;
               slot_full[fill_idx] = 1'b0;
            end
         end else if (slot_count[s] < lfr_pkg::RING_BYTES - 1) begin
            store_byte(item.symbol);
            slot_count[s]++;
         end
      end else begin
         s = read_idx;
         if (!slot_full[s]) begin
            word.data_byte      = 8'h00;
            word.last           = 1'b1;
            word.empty_res      = 1'b1;
            word.message_length = 7'd0;
            readout_queue.push_back(word);
         end else begin
            n = slot_count[s];
            a = slot_base[s];
            slot_full[s] = 1'b0;
            slot_count[s] = 0;
            for (int i = 0; i < n; i++) begin
               word.data_byte      = ring_copy[a];
               word.last           = (i == n - 1);
               word.empty_res      = 1'b0;
               word.message_length = 7'(n);
               readout_queue.push_back(word);
               a = (a + 1) % lfr_pkg::RING_BYTES;
            end
            read_idx = (s + 1) % lfr_pkg::NUM_SLOTS;
         end
      end
   endfunction

   // Request acceptance is seen at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_ready) begin
         frame_request(req_data);
         req_accepted++;
      end
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("line_framed_rx_ring regression: fail");
         $finish;
      end
   end

   // Driver: a new request goes out at a falling edge once the previous one was taken
   // and its gap has run out. An entry marked wait_drain waits for all readout to arrive.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted == req_issued) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() != 0 &&
                      !(pending[0].wait_drain && readout_queue.size() != 0)) begin
            next_entry = pending.pop_front();
            req_data  <= next_entry.request;
            req_valid <= 1'b1;
            req_issued++;
            send_gap = sender_gaps ? $urandom_range(10, 0) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: each readout byte is checked against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (readout_queue.size() == 0) begin
            note_failure($sformatf("unexpected readout: byte %02h last %0d empty %0d len %0d",
                                   rsp_data.data_byte, rsp_data.last, rsp_data.empty_res,
                                   rsp_data.message_length));
         end else begin
            if (rsp_data.data_byte !== readout_queue[0].data_byte ||
                rsp_data.last !== readout_queue[0].last ||
                rsp_data.empty_res !== readout_queue[0].empty_res ||
                rsp_data.message_length !== readout_queue[0].message_length) begin
               note_failure({$sformatf("readout mismatch: expected byte %02h last %0d ",
                                       readout_queue[0].data_byte, readout_queue[0].last),
                             $sformatf("empty %0d len %0d, ",
                                       readout_queue[0].empty_res,
                                       readout_queue[0].message_length),
                             $sformatf("got byte %02h last %0d empty %0d len %0d",
                                       rsp_data.data_byte, rsp_data.last,
                                       rsp_data.empty_res, rsp_data.message_length)});
            end
            void'(readout_queue.pop_front());
         end
         rsp_stall = receiver_gaps ? $urandom_range(10, 0) : 0;
      end
   end

   // The long receiver hold-off is counted here, apart from the per-byte stalls.
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0 || rsp_stall > 0) begin
         if (rsp_stall > 0) rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // One register access; a read is compared with the setting the framer copy holds.
   task automatic csr_cycle(input logic is_write, input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= lfr_pkg::ADDR_TERMINATOR_MAX;
      csr_pwdata  <= lfr_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         term_limit = value;
      end else if (csr_prdata[7:0] !== term_limit) begin
         note_failure($sformatf("terminator_max readback: expected %02h, got %02h",
                                term_limit, csr_prdata[7:0]));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending.size() != 0 || req_accepted != req_issued || readout_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_request(input logic op, input logic [7:0] sym, input logic drain);
      stim_type entry;
      entry.request.op     = op;
      entry.request.symbol = sym;
      entry.wait_drain     = drain;
      pending.push_back(entry);
   endtask

   // A byte that extends the message under the current setting.
   function automatic logic [7:0] pick_plain();
      if (term_limit == 8'hFF) return 8'($urandom);
      return 8'($urandom_range(255, int'(term_limit) + 1));
   endfunction

   function automatic logic [7:0] pick_stop();
      return 8'($urandom_range(int'(term_limit), 0));
   endfunction

   task automatic queue_message(input int len, input logic with_read);
      for (int k = 0; k < len; k++) queue_request(lfr_pkg::OP_RECEIVE, pick_plain(), 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, pick_stop(), 1'b0);
      if (with_read) queue_request(lfr_pkg::OP_READ, 8'($urandom), 1'b0);
   endtask

   // Mostly well-formed messages with random content, mixed with stray reads,
   // noise bytes and terminators on empty messages.
   task automatic queue_traffic(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         case ($urandom_range(9, 0))
            0, 1: queue_request(lfr_pkg::OP_READ, 8'($urandom), $urandom_range(5, 0) == 0);
            2: queue_request(lfr_pkg::OP_RECEIVE, 8'($urandom), 1'b0);
            3: queue_request(lfr_pkg::OP_RECEIVE, pick_stop(), 1'b0);
            default: queue_message($urandom_range(8, 1), $urandom_range(1, 0));
         endcase
      end
   endtask

   initial begin
      for (int i = 0; i < lfr_pkg::NUM_SLOTS; i++) begin
         slot_full[i]  = 1'b0;
         slot_count[i] = 0;
         slot_base[i]  = 0;
      end
      for (int i = 0; i < lfr_pkg::RING_BYTES; i++) ring_copy[i] = 8'h00;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The register must come out of reset at its documented value.
      csr_cycle(1'b0, 8'h00);

      // Directed part under the reset setting of 13.
      queue_request(lfr_pkg::OP_READ, 8'h00, 1'b0);      // nothing filed yet
      queue_request(lfr_pkg::OP_RECEIVE, 8'h00, 1'b0);   // terminator on an empty message
      queue_request(lfr_pkg::OP_READ, 8'hFF, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'd14, 1'b0);   // just above the threshold
      queue_request(lfr_pkg::OP_RECEIVE, 8'hFF, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'h80, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'd13, 1'b0);   // exactly at the threshold
      queue_request(lfr_pkg::OP_RECEIVE, 8'hAA, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'h55, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'h00, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'd7, 1'b0);    // ignored, message is empty
      queue_request(lfr_pkg::OP_READ, 8'h00, 1'b0);
      queue_request(lfr_pkg::OP_READ, 8'h00, 1'b0);
      queue_request(lfr_pkg::OP_READ, 8'h00, 1'b1);      // sender pauses for the readout
      queue_request(lfr_pkg::OP_RECEIVE, 8'd200, 1'b0);
      queue_request(lfr_pkg::OP_RECEIVE, 8'd12, 1'b0);
      queue_request(lfr_pkg::OP_READ, 8'h7F, 1'b0);
      wait_idle();

      // Setting 13 again, with a long receiver hold-off right behind a filed message.
      csr_cycle(1'b1, lfr_pkg::TERMINATOR_RESET);
      csr_cycle(1'b0, lfr_pkg::TERMINATOR_RESET);
      hold_requests++;
      queue_message(5, 1'b1);
      queue_traffic(1);
      wait_idle();

      // Only a zero byte terminates. No idling here. An unread message is overwritten
      // by an overlong one that saturates at the full ring.
      csr_cycle(1'b1, 8'h00);
      csr_cycle(1'b0, 8'h00);
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      queue_message(1, 1'b0);
      queue_message(lfr_pkg::RING_BYTES, 1'b0);
      queue_request(lfr_pkg::OP_READ, 8'($urandom), 1'b0);
      queue_request(lfr_pkg::OP_READ, 8'($urandom), 1'b0);
      wait_idle();

      // Every byte is a terminator, so nothing is ever filed.
      csr_cycle(1'b1, 8'hFF);
      csr_cycle(1'b0, 8'hFF);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      for (int k = 0; k < 4; k++) queue_request(1'($urandom), 8'($urandom), 1'b0);
      wait_idle();

      // A random setting; more messages than slots are filed before any read.
      csr_cycle(1'b1, 8'($urandom_range(254, 1)));
      csr_cycle(1'b0, 8'h00);
      for (int k = 0; k < lfr_pkg::NUM_SLOTS + 1; k++) begin
         queue_message($urandom_range(2, 1), 1'b0);
      end
      for (int k = 0; k < lfr_pkg::NUM_SLOTS + 1; k++) begin
         queue_request(lfr_pkg::OP_READ, 8'($urandom), 1'b0);
      end
      wait_idle();

      if (error_count == 0 && readout_queue.size() == 0) begin
         $display("line_framed_rx_ring regression: pass");
      end else begin
         $display("line_framed_rx_ring regression: fail");
      end
      $finish;
   end

endmodule
